>>> sv/gjk_2d_polygon_collision_core_macros.svh
// Assertion macros shared by the checker.
`ifndef GJK_2D_POLYGON_COLLISION_CORE_MACROS_SVH
`define GJK_2D_POLYGON_COLLISION_CORE_MACROS_SVH

// Property checked outside reset.
`define GJKC_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define GJKC_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/gjkc_pkg.sv
`timescale 1ns / 1ps
package gjkc_pkg;

  // Default sizes.
  localparam int MaxVertsDef  = 64;
  localparam int CoordBitsDef = 16;
  localparam int QueueDepth   = 2;

  // Reset value of the iteration limit.
  localparam logic [7:0] LimitReset = 8'd32;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_SEPARATE = 2'd0,
    STATUS_COLLIDE  = 2'd1,
    STATUS_GAVE_UP  = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  // Sequencer states of the test engine.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOP,
    ST_A_RD,
    ST_A_DOT,
    ST_A_CMP,
    ST_B_RD,
    ST_B_DOT,
    ST_B_CMP,
    ST_SUP,
    ST_P_DOT,
    ST_P_CHK,
    ST_T_AB,
    ST_T_ABN,
    ST_T_ABO,
    ST_T_ABC,
    ST_T_AC,
    ST_T_ACN,
    ST_T_ACO,
    ST_T_ACC,
    ST_L_SET,
    ST_L_DOT,
    ST_L_CHK
  } state_e;

endpackage

>>> sv/gjkc_queue.sv
`timescale 1ns / 1ps
module gjkc_queue import gjkc_pkg::*; #(
  parameter int WIDTH = 2 * CoordBitsDef + 2,
  parameter int DEPTH = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // Storage for queued words.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers wrap at the depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> sv/gjkc_engine.sv
`timescale 1ns / 1ps
module gjkc_engine import gjkc_pkg::*; #(
  parameter int MAX_VERTS  = MaxVertsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  logic [2*COORD_BITS+1:0] q_data_i,
  output logic                    q_pop_o,
  input  logic [7:0]              limit_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic [7:0]              iterations_used_o
);

  localparam int C  = COORD_BITS;
  localparam int W  = C + 3;
  localparam int PW = 2 * W + 1;
  localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW = $clog2(MAX_VERTS + 1);

  state_e state_q, state_d;

  // Vertex stores.
  logic [2*C-1:0] mem_a [MAX_VERTS];
  logic [2*C-1:0] mem_b [MAX_VERTS];
  logic [2*C-1:0] rd_a_q, rd_b_q;

  logic [CW-1:0] cnt_a_q, cnt_b_q, idx_q;
  logic [1:0]    size_q;
  logic [7:0]    n_q;

  logic signed [W-1:0]  d_x_q, d_y_q, dt_x_q, dt_y_q;
  logic signed [W-1:0]  pa_x_q, pa_y_q, bv_x_q, bv_y_q, p_x_q, p_y_q;
  logic signed [W-1:0]  s_x_q [3];
  logic signed [W-1:0]  s_y_q [3];
  logic signed [PW-1:0] best_q, dot_q;
  logic                 first_q;

  logic                 valid_q;
  logic [1:0]           status_q;
  logic [7:0]           iter_q;

  // Command word fields.
  logic           cmd_go, cmd_sel;
  logic [2*C-1:0] cmd_vtx;
  assign cmd_go  = q_data_i[2*C+1];
  assign cmd_sel = q_data_i[2*C];
  assign cmd_vtx = q_data_i[2*C-1:0];

  logic pop;
  assign pop     = (state_q == ST_IDLE) && !q_empty_i;
  assign q_pop_o = pop;

  // Store writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (pop && !cmd_sel && (cnt_a_q < CW'(MAX_VERTS))) begin
      mem_a[cnt_a_q[IW-1:0]] <= cmd_vtx;
    end
    if (pop && cmd_sel && (cnt_b_q < CW'(MAX_VERTS))) begin
      mem_b[cnt_b_q[IW-1:0]] <= cmd_vtx;
    end
    rd_a_q <= mem_a[idx_q[IW-1:0]];
    rd_b_q <= mem_b[idx_q[IW-1:0]];
  end

  // Vertex under test, sign extended.
  logic [2*C-1:0]      rd;
  logic signed [W-1:0] v_x, v_y;
  assign rd  = (state_q == ST_B_DOT || state_q == ST_B_CMP) ? rd_b_q : rd_a_q;
  assign v_x = {{3{rd[C-1]}}, rd[C-1:0]};
  assign v_y = {{3{rd[2*C-1]}}, rd[2*C-1:C]};

  // Simplex geometry: newest point and its edges.
  logic signed [W-1:0] a_x, a_y, ab_x, ab_y, ac_x, ac_y, ao_x, ao_y;
  assign a_x  = (size_q == 2'd3) ? s_x_q[2] : s_x_q[1];
  assign a_y  = (size_q == 2'd3) ? s_y_q[2] : s_y_q[1];
  assign ab_x = s_x_q[1] - a_x;
  assign ab_y = s_y_q[1] - a_y;
  assign ac_x = s_x_q[0] - a_x;
  assign ac_y = s_y_q[0] - a_y;
  assign ao_x = -a_x;
  assign ao_y = -a_y;

  // Support point from the two furthest vertices.
  logic signed [W-1:0] sp_x, sp_y;
  assign sp_x = pa_x_q - bv_x_q;
  assign sp_y = pa_y_q - bv_y_q;

  // Shared dot product unit, result registered.
  logic signed [W-1:0]   u_x, u_y, w_x, w_y;
  logic signed [2*W-1:0] m0, m1;
  logic signed [PW-1:0]  dot_w;

  always_comb begin
    u_x = '0; u_y = '0; w_x = '0; w_y = '0;
    unique case (state_q)
      ST_A_DOT: begin u_x = v_x; u_y = v_y; w_x = d_x_q; w_y = d_y_q; end
      ST_B_DOT: begin u_x = v_x; u_y = v_y; w_x = -d_x_q; w_y = -d_y_q; end
      ST_P_DOT: begin u_x = p_x_q; u_y = p_y_q; w_x = d_x_q; w_y = d_y_q; end
      ST_T_AB:  begin u_x = -ab_y; u_y = ab_x; w_x = ac_x; w_y = ac_y; end
      ST_T_AC:  begin u_x = -ac_y; u_y = ac_x; w_x = ab_x; w_y = ab_y; end
      ST_T_ABO, ST_T_ACO, ST_L_DOT: begin
        u_x = dt_x_q; u_y = dt_y_q; w_x = ao_x; w_y = ao_y;
      end
      default: begin u_x = '0; u_y = '0; w_x = '0; w_y = '0; end
    endcase
  end

  assign m0    = u_x * w_x;
  assign m1    = u_y * w_y;
  assign dot_w = {m0[2*W-1], m0} + {m1[2*W-1], m1};

  logic last_a, last_b;
  assign last_a = ((idx_q + 1'b1) == cnt_a_q);
  assign last_b = ((idx_q + 1'b1) == cnt_b_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (pop && cmd_go) state_d = ST_CHECK;
      ST_CHECK: state_d = (cnt_a_q == '0 || cnt_b_q == '0) ? ST_IDLE : ST_A_RD;
      ST_LOOP:  state_d = (n_q >= limit_i) ? ST_IDLE : ST_A_RD;
      ST_A_RD:  state_d = ST_A_DOT;
      ST_A_DOT: state_d = ST_A_CMP;
      ST_A_CMP: state_d = last_a ? ST_B_RD : ST_A_RD;
      ST_B_RD:  state_d = ST_B_DOT;
      ST_B_DOT: state_d = ST_B_CMP;
      ST_B_CMP: state_d = last_b ? ST_SUP : ST_B_RD;
      ST_SUP:   state_d = first_q ? ST_LOOP : ST_P_DOT;
      ST_P_DOT: state_d = ST_P_CHK;
      ST_P_CHK: begin
        if (dot_q <= 0) state_d = ST_IDLE;
        else if (size_q == 2'd3) state_d = ST_T_AB;
        else state_d = ST_L_SET;
      end
      ST_T_AB:  state_d = ST_T_ABN;
      ST_T_ABN: state_d = ST_T_ABO;
      ST_T_ABO: state_d = ST_T_ABC;
      ST_T_ABC: state_d = (dot_q > 0) ? ST_LOOP : ST_T_AC;
      ST_T_AC:  state_d = ST_T_ACN;
      ST_T_ACN: state_d = ST_T_ACO;
      ST_T_ACO: state_d = ST_T_ACC;
      ST_T_ACC: state_d = (dot_q > 0) ? ST_LOOP : ST_IDLE;
      ST_L_SET: state_d = ST_L_DOT;
      ST_L_DOT: state_d = ST_L_CHK;
      ST_L_CHK: state_d = ST_LOOP;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Result decision for this cycle.
  logic    emit;
  status_e emit_status;
  always_comb begin
    emit        = 1'b0;
    emit_status = STATUS_SEPARATE;
    unique case (state_q)
      ST_CHECK: if (cnt_a_q == '0 || cnt_b_q == '0) begin
        emit = 1'b1; emit_status = STATUS_EMPTY;
      end
      ST_LOOP: if (n_q >= limit_i) begin
        emit = 1'b1; emit_status = STATUS_GAVE_UP;
      end
      ST_P_CHK: if (dot_q <= 0) begin
        emit = 1'b1; emit_status = STATUS_SEPARATE;
      end
      ST_T_ACC: if (!(dot_q > 0)) begin
        emit = 1'b1; emit_status = STATUS_COLLIDE;
      end
      default: begin emit = 1'b0; emit_status = STATUS_SEPARATE; end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      size_q   <= '0;
      valid_q  <= 1'b0;
      status_q <= STATUS_SEPARATE;
      iter_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= emit;
      if (emit) begin
        status_q <= emit_status;
        iter_q   <= (emit_status == STATUS_EMPTY) ? 8'd0 : n_q;
        cnt_a_q  <= '0;
        cnt_b_q  <= '0;
        size_q   <= '0;
      end else if (pop) begin
        if (!cmd_sel && cnt_a_q < CW'(MAX_VERTS)) cnt_a_q <= cnt_a_q + 1'b1;
        if (cmd_sel && cnt_b_q < CW'(MAX_VERTS)) cnt_b_q <= cnt_b_q + 1'b1;
      end else if (state_q == ST_SUP) begin
        size_q <= first_q ? 2'd1 : ((size_q > 2'd2) ? 2'd3 : size_q + 1'b1);
      end else if ((state_q == ST_T_ABC && dot_q > 0) ||
                   (state_q == ST_T_ACC && dot_q > 0)) begin
        size_q <= 2'd2;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dot_q <= dot_w;
    unique case (state_q)
      ST_CHECK: begin
        d_x_q   <= W'(1);
        d_y_q   <= -W'(1);
        n_q     <= '0;
        first_q <= 1'b1;
        idx_q   <= '0;
      end
      ST_LOOP: begin
        if (!(n_q >= limit_i)) n_q <= n_q + 1'b1;
        idx_q <= '0;
      end
      ST_A_CMP: begin
        if (idx_q == '0 || dot_q > best_q) begin
          best_q <= dot_q; bv_x_q <= v_x; bv_y_q <= v_y;
        end
        idx_q <= last_a ? '0 : idx_q + 1'b1;
      end
      ST_B_RD: begin
        if (idx_q == '0) begin pa_x_q <= bv_x_q; pa_y_q <= bv_y_q; end
      end
      ST_B_CMP: begin
        if (idx_q == '0 || dot_q > best_q) begin
          best_q <= dot_q; bv_x_q <= v_x; bv_y_q <= v_y;
        end
        idx_q <= last_b ? '0 : idx_q + 1'b1;
      end
      ST_SUP: begin
        p_x_q <= sp_x;
        p_y_q <= sp_y;
        if (first_q) begin
          s_x_q[0] <= sp_x; s_y_q[0] <= sp_y;
          d_x_q <= -d_x_q; d_y_q <= -d_y_q;
          first_q <= 1'b0;
        end else if (size_q >= 2'd2) begin
          s_x_q[2] <= sp_x; s_y_q[2] <= sp_y;
        end else begin
          s_x_q[1] <= sp_x; s_y_q[1] <= sp_y;
        end
      end
      ST_T_ABN: begin
        if (dot_q > 0) begin dt_x_q <= ab_y; dt_y_q <= -ab_x; end
        else begin dt_x_q <= -ab_y; dt_y_q <= ab_x; end
      end
      ST_T_ABC: begin
        if (dot_q > 0) begin
          d_x_q <= dt_x_q; d_y_q <= dt_y_q;
          s_x_q[0] <= s_x_q[1]; s_y_q[0] <= s_y_q[1];
          s_x_q[1] <= a_x; s_y_q[1] <= a_y;
        end
      end
      ST_T_ACN: begin
        if (dot_q > 0) begin dt_x_q <= ac_y; dt_y_q <= -ac_x; end
        else begin dt_x_q <= -ac_y; dt_y_q <= ac_x; end
      end
      ST_T_ACC: begin
        d_x_q <= dt_x_q; d_y_q <= dt_y_q;
        if (dot_q > 0) begin s_x_q[1] <= a_x; s_y_q[1] <= a_y; end
      end
      ST_L_SET: begin
        dt_x_q <= -ac_y; dt_y_q <= ac_x;
      end
      ST_L_CHK: begin
        if (dot_q < 0) begin d_x_q <= -dt_x_q; d_y_q <= -dt_y_q; end
        else begin d_x_q <= dt_x_q; d_y_q <= dt_y_q; end
      end
      default: begin end
    endcase
  end

  assign result_valid_o    = valid_q;
  assign status_o          = status_q;
  assign iterations_used_o = iter_q;

endmodule

>>> sv/gjk_2d_polygon_collision_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     start_i high, busy_o low  shape_select_i, vertex_x_i, vertex_y_i, go_i
// result    result_valid_o, 1 cycle   status_o, iterations_used_o
// config    cfg_we_i                  cfg_data_i (iteration limit)
//
// A vertex word is taken while the two-word queue has room.
// A go word runs a first support scan over every stored vertex of both shapes,
// then per refinement step another scan over the vertices plus loop and simplex
// work on the shared dot product unit.
// Reset clears the queue, both vertex counts and the result strobe.
// Results cannot be stalled; busy_o rises only while the queue is full.
module gjk_2d_polygon_collision_core import gjkc_pkg::*; #(
  parameter int MAX_VERTS  = MaxVertsDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  shape_select_i,
  input  logic [COORD_BITS-1:0] vertex_x_i,
  input  logic [COORD_BITS-1:0] vertex_y_i,
  input  logic                  go_i,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_data_i,
  output logic                  result_valid_o,
  output logic [1:0]            status_o,
  output logic [7:0]            iterations_used_o
);

  localparam int CMDW = 2 * COORD_BITS + 2;

  logic [7:0]      limit_q;
  logic [CMDW-1:0] cmd, q_data;
  logic            q_full, q_empty, q_pop;

  // Iteration limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Front end packs each accepted word into a command.
  assign cmd    = {go_i, shape_select_i, vertex_y_i, vertex_x_i};
  assign busy_o = q_full;

  gjkc_queue #(
    .WIDTH (CMDW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start_i),
    .data_i  (cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  gjkc_engine #(
    .MAX_VERTS  (MAX_VERTS),
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_data),
    .q_pop_o           (q_pop),
    .limit_i           (limit_q),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .iterations_used_o (iterations_used_o)
  );

endmodule

>>> sv/gjkc_checker.sv
`timescale 1ns / 1ps
`include "gjk_2d_polygon_collision_core_macros.svh"
module gjkc_props import gjkc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy_i,
  input logic       result_valid_i,
  input logic [1:0] status_i,
  input logic [7:0] iterations_used_i
);

  logic empty_res, decided_res, no_steps;
  assign empty_res   = result_valid_i && (status_i == STATUS_EMPTY);
  assign decided_res = result_valid_i &&
                       (status_i == STATUS_SEPARATE || status_i == STATUS_COLLIDE);
  assign no_steps    = (iterations_used_i == 8'd0);

  // Each result strobe is isolated.
  `GJKC_ASSERT_RUN(a_strobe_single, clk_i, rst_ni, result_valid_i |=> !result_valid_i, "strobe")

  // An empty shape is decided before any step.
  `GJKC_ASSERT_RUN(a_empty_zero, clk_i, rst_ni, empty_res |-> no_steps, "empty shape with steps")

  // A geometric decision takes at least one step.
  `GJKC_ASSERT_RUN(a_decided_steps, clk_i, rst_ni, decided_res |-> !no_steps, "no step taken")

  // Reset keeps the ports quiet.
  `GJKC_ASSERT_ALL(a_reset_quiet, clk_i, !rst_ni |-> (!busy_i && !result_valid_i), "reset")

endmodule

bind gjk_2d_polygon_collision_core gjkc_props u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .busy_i            (busy_o),
  .result_valid_i    (result_valid_o),
  .status_i          (status_o),
  .iterations_used_i (iterations_used_o)
);
